>>> src/vtpd_pkg.sv
// shared constants and types for the vertex transform and perspective divide unit
// no dependencies; compile first
package vtpd_pkg;

  localparam int DataW    = 32;                      // q16.16 word
  localparam int FracBits = 16;                      // fraction bits of the fixed point
  localparam int ProdW    = 2 * DataW;               // full product
  localparam int SumW     = ProdW - FracBits + 2;    // exact row sum, never wraps
  localparam int QuoW     = DataW + 1;               // quotient bits developed
  localparam int PreShift = QuoW - FracBits;         // top of dividend held by first remainder
  localparam int DivLat   = QuoW + 3;                // abs, range check, steps, clamp
  localparam int MatDepth = 16;
  localparam int IdxW     = $clog2(MatDepth);
  localparam int InDataW  = ((IdxW + 4 * DataW + 7) / 8) * 8;
  localparam int OutDataW = 3 * DataW;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } opcode_e;

endpackage

>>> src/vtpd_div_lane.sv
// one pipelined fixed-point divide lane: (num * 2^frac) / den, toward zero, clamped
// depends on vtpd_pkg
module vtpd_div_lane (
  input  logic                               clk_i,
  input  logic                               en_i,
  input  logic signed [vtpd_pkg::SumW-1:0]   num_i,
  input  logic signed [vtpd_pkg::SumW-1:0]   den_i,
  output logic        [vtpd_pkg::DataW-1:0]  quo_o,
  output logic                               sat_o
);
  import vtpd_pkg::*;

  // magnitude stage
  logic [SumW-1:0] an_q, ad_q;
  logic            neg_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q  <= num_i[SumW-1] ? SumW'(-num_i) : num_i;
      ad_q  <= den_i[SumW-1] ? SumW'(-den_i) : den_i;
      neg_q <= num_i[SumW-1] ^ den_i[SumW-1];
    end
  end

  // step arrays, index 0 is the range check stage
  logic [SumW-1:0] rem_q  [QuoW+1];
  logic [SumW-1:0] dv_q   [QuoW+1];
  logic [QuoW-1:0] low_q  [QuoW+1];
  logic [QuoW-1:0] quo_q  [QuoW+1];
  logic            ovf_q  [QuoW+1];
  logic            sgn_q  [QuoW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // quotient needs more than QuoW bits when the top of the dividend reaches the divisor
      ovf_q[0] <= (an_q >> PreShift) >= ad_q;
      rem_q[0] <= (an_q >> PreShift);
      low_q[0] <= {an_q[PreShift-1:0], FracBits'(0)};
      dv_q[0]  <= ad_q;
      quo_q[0] <= '0;
      sgn_q[0] <= neg_q;
    end
  end

  for (genvar s = 1; s <= QuoW; s++) begin : g_step
    logic [SumW:0] shl;
    logic          ge;
    assign shl = {rem_q[s-1], low_q[s-1][QuoW-1]};
    assign ge  = shl >= {1'b0, dv_q[s-1]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? SumW'(shl - {1'b0, dv_q[s-1]}) : shl[SumW-1:0];
        low_q[s] <= {low_q[s-1][QuoW-2:0], 1'b0};
        quo_q[s] <= {quo_q[s-1][QuoW-2:0], ge};
        dv_q[s]  <= dv_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        sgn_q[s] <= sgn_q[s-1];
      end
    end
  end

  // clamp and restore sign
  logic [QuoW-1:0] lim, mag;
  logic            sat;
  assign lim = sgn_q[QuoW] ? QuoW'(1) << (DataW - 1) : (QuoW'(1) << (DataW - 1)) - QuoW'(1);
  assign sat = ovf_q[QuoW] || (quo_q[QuoW] > lim);
  assign mag = sat ? lim : quo_q[QuoW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= sgn_q[QuoW] ? DataW'(-mag[DataW-1:0]) : mag[DataW-1:0];
      sat_o <= sat;
    end
  end

endmodule

>>> src/vertex_transform_perspective_divide_unit.sv
// top level: 4x4 matrix store, product and sum stages, three divide lanes
// depends on vtpd_pkg and vtpd_div_lane
//
// channel  dir  bits        contents
// s_axis   in   tdata 136   entry_index[3:0] entry_value[35:4] pos_x[67:36] pos_y[99:68]
//                           pos_z[131:100], zero fill
//               tuser 1     opcode (0 load, 1 transform)
// m_axis   out  tdata 96    out_x[31:0] out_y[63:32] out_z[95:64]
//               tuser 2     divide_error[0] saturated[1]
//
// one word accepted per cycle while the output is not stalled; a transform result passes the
// product stage, loaded at its accepting edge, then the sum stage and 36 divide lane stages:
// magnitude, range check, 33 quotient bit steps, clamp
// a load writes the matrix as it is accepted and yields no result
// the whole pipe holds while a result waits at the output; nothing is dropped or repeated
// reset clears the matrix to zero and all valid bits
module vertex_transform_perspective_divide_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // entry_index, entry_value, pos_x, pos_y, pos_z, zero fill
  input  logic [vtpd_pkg::InDataW-1:0]        s_axis_tdata_i,
  // opcode
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // out_x, out_y, out_z
  output logic [vtpd_pkg::OutDataW-1:0]       m_axis_tdata_o,
  // divide_error, saturated
  output logic [1:0]                          m_axis_tuser_o
);
  import vtpd_pkg::*;

  logic en, acc;
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign acc             = s_axis_tvalid_i && s_axis_tready_o;

  // input fields
  logic [IdxW-1:0]         idx;
  logic signed [DataW-1:0] val;
  logic signed [DataW-1:0] pos [3];
  assign idx    = s_axis_tdata_i[IdxW-1:0];
  assign val    = s_axis_tdata_i[IdxW +: DataW];
  assign pos[0] = s_axis_tdata_i[IdxW + DataW +: DataW];
  assign pos[1] = s_axis_tdata_i[IdxW + 2*DataW +: DataW];
  assign pos[2] = s_axis_tdata_i[IdxW + 3*DataW +: DataW];

  // matrix store, column major
  logic signed [DataW-1:0] mat_q [MatDepth];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MatDepth; i++) mat_q[i] <= '0;
    end else if (acc && opcode_e'(s_axis_tuser_i) == OP_LOAD) begin
      mat_q[idx] <= val;
    end
  end

  // stage 1: twelve products and the translation column
  logic signed [ProdW-1:0] prod_q  [4][3];
  logic signed [DataW-1:0] trans_q [4];
  logic                    v1_q, v2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 3; k++) prod_q[c][k] <= ProdW'(pos[k]) * ProdW'(mat_q[4*k + c]);
        trans_q[c] <= mat_q[12 + c];
      end
    end
  end

  // stage 2: row sums, products floored to the fixed point
  logic signed [SumW-1:0] t_q [4];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 4; c++) begin
        t_q[c] <= SumW'(prod_q[c][0] >>> FracBits) + SumW'(prod_q[c][1] >>> FracBits)
                + SumW'(prod_q[c][2] >>> FracBits) + SumW'(trans_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v1_q <= acc && opcode_e'(s_axis_tuser_i) == OP_XFORM;
      v2_q <= v1_q;
    end
  end

  // divide lanes for x, y, z by w
  logic [DataW-1:0] quo [3];
  logic             sat [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    vtpd_div_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (t_q[c]),
      .den_i (t_q[3]),
      .quo_o (quo[c]),
      .sat_o (sat[c])
    );
  end

  // valid and zero-w flag follow the lanes
  logic vld_q  [DivLat];
  logic zero_q [DivLat];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivLat; i++) vld_q[i] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= v2_q;
      for (int i = 1; i < DivLat; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      zero_q[0] <= t_q[3] == '0;
      for (int i = 1; i < DivLat; i++) zero_q[i] <= zero_q[i-1];
    end
  end

  logic zw;
  assign zw              = zero_q[DivLat-1];
  assign m_axis_tvalid_o = vld_q[DivLat-1];
  assign m_axis_tdata_o  = zw ? '0 : {quo[2], quo[1], quo[0]};
  assign m_axis_tuser_o  = {!zw && (sat[0] || sat[1] || sat[2]), zw};

`ifndef SYNTHESIS
  a_zero_w_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0 && !m_axis_tuser_o[1])
    else $error("zero w result carries data or saturation");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_load_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && opcode_e'(s_axis_tuser_i) == OP_LOAD |=> !v1_q)
    else $error("load entered the result pipe");
`endif

endmodule
